// ===== sv/dq_pkg.sv =====
package dq_pkg;

   localparam int DEPTH     = 16;
   localparam int WORD_BITS = 32;
   localparam int PTR_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [PTR_BITS-1:0]  ptr_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;

   typedef enum logic [2:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_REAR  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_REAR   = 3'd3,
      MODE_PEEK_FRONT = 3'd4,
      MODE_PEEK_REAR  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load_op;
      logic exec;
      logic capture;
   } cmd_type;

   typedef struct packed {
      logic is_read;
   } dp_status_type;

endpackage

// ===== sv/dq_ram.sv =====
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/dq_ctrl.sv =====
module dq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  rsp_stall,
   input  dq_pkg::dp_status_type dp_status,
   output dq_pkg::cmd_type       cmd,
   output logic                  req_stall,
   output logic                  rsp_valid
);

   dq_pkg::state_type state_ff;
   dq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         dq_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_op = 1'b1;
               state_in    = dq_pkg::S_EXEC;
            end
         end
         dq_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = dp_status.is_read ? dq_pkg::S_READ : dq_pkg::S_RESP;
         end
         dq_pkg::S_READ: begin
            cmd.capture = 1'b1;
            state_in    = dq_pkg::S_RESP;
         end
         dq_pkg::S_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = dq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dq_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/dq_datapath.sv =====
module dq_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  dq_pkg::cmd_type       cmd,
   input  logic [2:0]            req_mode,
   input  logic signed [31:0]    req_value,
   output dq_pkg::dp_status_type dp_status,
   output logic signed [31:0]    rsp_result_word,
   output logic [1:0]            rsp_status,
   output logic [4:0]            rsp_fill_count
);

   dq_pkg::mode_type   op_mode_ff;
   dq_pkg::word_type   op_value_ff;
   dq_pkg::ptr_type    front_ff, front_in;
   dq_pkg::ptr_type    rear_ff, rear_in;
   dq_pkg::cnt_type    count_ff, count_in;
   logic signed [31:0] rsp_word_ff;
   dq_pkg::status_type rsp_status_ff;
   dq_pkg::cnt_type    rsp_count_ff;

   dq_pkg::ptr_type    front_prev, front_next, rear_prev, rear_next;
   logic               is_empty, is_full, is_read;
   dq_pkg::status_type st;
   logic [31:0]        word_out;
   logic               wr_en, rd_en;
   dq_pkg::ptr_type    wr_addr, rd_addr;
   dq_pkg::word_type   rd_data;

   localparam dq_pkg::ptr_type LastPos = dq_pkg::ptr_type'(dq_pkg::DEPTH - 1);

   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == dq_pkg::cnt_type'(dq_pkg::DEPTH));
   assign front_prev = (front_ff == '0) ? LastPos : front_ff - 1'b1;
   assign front_next = (front_ff == LastPos) ? '0 : front_ff + 1'b1;
   assign rear_prev  = (rear_ff == '0) ? LastPos : rear_ff - 1'b1;
   assign rear_next  = (rear_ff == LastPos) ? '0 : rear_ff + 1'b1;

   always_comb begin
      front_in = front_ff;
      rear_in  = rear_ff;
      count_in = count_ff;
      st       = dq_pkg::ST_OK;
      word_out = '0;
      is_read  = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = front_ff;
      rd_addr  = front_ff;
      case (op_mode_ff) inside
         dq_pkg::MODE_PUSH_FRONT: begin
            if (is_full) begin
               st = dq_pkg::ST_FULL;
            end else begin
               front_in = front_prev;
               wr_en    = 1'b1;
               wr_addr  = front_prev;
               count_in = count_ff + 1'b1;
            end
         end
         dq_pkg::MODE_PUSH_REAR: begin
            if (is_full) begin
               st = dq_pkg::ST_FULL;
            end else begin
               rear_in  = rear_next;
               wr_en    = 1'b1;
               wr_addr  = rear_next;
               count_in = count_ff + 1'b1;
            end
         end
         dq_pkg::MODE_POP_FRONT, dq_pkg::MODE_PEEK_FRONT: begin
            if (is_empty) begin
               st       = dq_pkg::ST_EMPTY;
               word_out = '1;
            end else begin
               is_read = 1'b1;
               rd_addr = front_ff;
               if (op_mode_ff == dq_pkg::MODE_POP_FRONT) begin
                  front_in = front_next;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         dq_pkg::MODE_POP_REAR, dq_pkg::MODE_PEEK_REAR: begin
            if (is_empty) begin
               st       = dq_pkg::ST_EMPTY;
               word_out = '1;
            end else begin
               is_read = 1'b1;
               rd_addr = rear_ff;
               if (op_mode_ff == dq_pkg::MODE_POP_REAR) begin
                  rear_in  = rear_prev;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rd_en = cmd.exec && is_read;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= LastPos;
         count_ff <= '0;
      end else if (cmd.exec) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_op) begin
         op_mode_ff  <= dq_pkg::mode_type'(req_mode);
         op_value_ff <= dq_pkg::word_type'(req_value);
      end
      if (cmd.exec) begin
         rsp_status_ff <= st;
         rsp_count_ff  <= count_in;
         rsp_word_ff   <= word_out;
      end else if (cmd.capture) begin
         rsp_word_ff <= 32'(rd_data);
      end
   end

   dq_ram #(
      .WIDTH(dq_pkg::WORD_BITS),
      .DEPTH(dq_pkg::DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (cmd.exec && wr_en),
      .wr_addr(wr_addr),
      .wr_data(op_value_ff),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign dp_status.is_read = is_read;
   assign rsp_result_word   = rsp_word_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_fill_count    = 5'(rsp_count_ff);

endmodule

// ===== sv/double_ended_queue.sv =====
// bounded double-ended queue of signed words held in a ring buffer ram
// request channel: req_valid / req_stall carry req_mode and req_value
//   modes: push front, push rear, pop front, pop rear, peek front, peek rear
// response channel: rsp_valid / rsp_stall carry rsp_result_word,
//   rsp_status (ok, empty, full) and rsp_fill_count after the operation
// exactly one response word per request word, in request order
// one request is in flight at a time; req_stall is high until its response
//   has been taken
// pushes, empty reads and full pushes pass from acceptance through the exec
//   state to the response state; pops and peeks also pass the read state, for
//   the registered read port of the ring ram
// a stalled response holds its value and blocks new requests
// synchronous reset empties the queue; ram contents are not cleared and
//   need no clearing pass
module double_ended_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_word,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_fill_count
);

   dq_pkg::cmd_type       cmd;
   dq_pkg::dp_status_type dp_status;

   dq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .rsp_stall(rsp_stall),
      .dp_status(dp_status),
      .cmd      (cmd),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid)
   );

   dq_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_mode       (req_mode),
      .req_value      (req_value),
      .dp_status      (dp_status),
      .rsp_result_word(rsp_result_word),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count)
   );

   a_no_accept_while_pending: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !rsp_valid)
      else $error("request taken while response pending");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fill_count <= 5'(dq_pkg::DEPTH))
      else $error("fill count beyond depth");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == dq_pkg::ST_FULL)
         |-> rsp_fill_count == 5'(dq_pkg::DEPTH))
      else $error("full status with room left");

   a_one_response: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("response repeated");

endmodule

// ===== tb/sv/double_ended_queue_test.sv =====
`timescale 1ns / 1ps

module double_ended_queue_test;

   localparam logic [2:0] MODE_UNUSED_A = 3'd6;
   localparam logic [2:0] MODE_UNUSED_B = 3'd7;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_WORDS = 1800;
   localparam int LONG_HOLD = 300;

   typedef struct {
      logic [31:0]        word;
      dq_pkg::status_type status;
      dq_pkg::cnt_type    fill;
   } outcome_type;

   class deque_board;
      dq_pkg::word_type slots [dq_pkg::DEPTH];
      dq_pkg::ptr_type  head;
      dq_pkg::ptr_type  tail;
      dq_pkg::cnt_type  held;
      outcome_type      awaited [$];
      int               errors;

      function new();
         head = '0;
         tail = dq_pkg::ptr_type'(dq_pkg::DEPTH - 1);
         held = '0;
         errors = 0;
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction

      function void note_request(logic [2:0] mode, logic [31:0] value);
         outcome_type o;
         o.word = '0;
         o.status = dq_pkg::ST_OK;
         case (mode)
            dq_pkg::MODE_PUSH_FRONT, dq_pkg::MODE_PUSH_REAR: begin
               if (held == dq_pkg::DEPTH) begin
                  o.status = dq_pkg::ST_FULL;
               end else if (mode == dq_pkg::MODE_PUSH_FRONT) begin
                  head = head - 1'b1;
                  slots[head] = value;
                  held = held + 1'b1;
               end else begin
                  tail = tail + 1'b1;
                  slots[tail] = value;
                  held = held + 1'b1;
               end
            end
            dq_pkg::MODE_POP_FRONT, dq_pkg::MODE_POP_REAR,
            dq_pkg::MODE_PEEK_FRONT, dq_pkg::MODE_PEEK_REAR: begin
               if (held == 0) begin
                  o.word = '1;
                  o.status = dq_pkg::ST_EMPTY;
               end else if (mode == dq_pkg::MODE_POP_FRONT ||
                            mode == dq_pkg::MODE_PEEK_FRONT) begin
                  o.word = slots[head];
                  if (mode == dq_pkg::MODE_POP_FRONT) begin
                     head = head + 1'b1;
                     held = held - 1'b1;
                  end
               end else begin
                  o.word = slots[tail];
                  if (mode == dq_pkg::MODE_POP_REAR) begin
                     tail = tail - 1'b1;
                     held = held - 1'b1;
                  end
               end
            end
            default: ;
         endcase
         o.fill = held;
         awaited.push_back(o);
      endfunction

      function void check_response(logic [31:0] word, logic [1:0] status, logic [4:0] fill);
         outcome_type o;
         if (awaited.size() == 0) begin
            $error("response word with nothing outstanding");
            errors++;
            return;
         end
         o = awaited.pop_front();
         if (word !== o.word) begin
            $error("rsp_result_word: expected %0d, got %0d", $signed(o.word), $signed(word));
            errors++;
         end
         if (status !== o.status) begin
            $error("rsp_status: expected %0d, got %0d", o.status, status);
            errors++;
         end
         if (fill !== o.fill) begin
            $error("rsp_fill_count: expected %0d, got %0d", o.fill, fill);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_mode;
   logic signed [31:0] req_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_result_word;
   logic [1:0]         rsp_status;
   logic [4:0]         rsp_fill_count;

   deque_board board = new();
   bit long_hold_ask;
   int cycles;

   double_ended_queue u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_word (rsp_result_word),
      .rsp_status      (rsp_status),
      .rsp_fill_count  (rsp_fill_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 3);
      if (r < 92) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   function automatic int sender_gap();
      if ($urandom_range(0, 99) < 55) return 0;
      return idle_span();
   endfunction

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 15))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] random_mode(int push_pct);
      if ($urandom_range(0, 99) < 2)
         return $urandom_range(0, 1) ? MODE_UNUSED_A : MODE_UNUSED_B;
      if ($urandom_range(0, 99) < push_pct)
         return $urandom_range(0, 1) ? dq_pkg::MODE_PUSH_REAR : dq_pkg::MODE_PUSH_FRONT;
      return 3'($urandom_range(dq_pkg::MODE_POP_FRONT, dq_pkg::MODE_PEEK_REAR));
   endfunction

   task automatic send_word(logic [2:0] mode, logic [31:0] value, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      board.note_request(mode, value);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   // receiver side: random stalls, calm stretches, one long hold on request
   initial begin
      int hold_left;
      int calm_left;
      int r;
      hold_left = 0;
      calm_left = 0;
      rsp_stall = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            board.check_response(rsp_result_word, rsp_status, rsp_fill_count);
         if (long_hold_ask) begin
            long_hold_ask = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (calm_left > 0) begin
            rsp_stall <= 1'b0;
            calm_left--;
         end else begin
            rsp_stall <= 1'b0;
            r = $urandom_range(0, 99);
            if (r < 3) calm_left = $urandom_range(50, 300);
            else if (r < 40) hold_left = idle_span();
         end
      end
   end

   initial begin
      int sent;
      int seg;
      int seg_len;
      int push_pct;
      bit quiet;
      logic [31:0] v;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = '0;
      req_value = '0;
      long_hold_ask = 1'b0;
      cycles = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty reads and unused codes
      send_word(dq_pkg::MODE_PEEK_FRONT, 32'h1234_5678, sender_gap());
      send_word(dq_pkg::MODE_PEEK_REAR, 32'h0, sender_gap());
      send_word(dq_pkg::MODE_POP_FRONT, 32'h0, sender_gap());
      send_word(dq_pkg::MODE_POP_REAR, 32'hffff_ffff, sender_gap());
      send_word(MODE_UNUSED_A, 32'h5a5a_5a5a, sender_gap());
      send_word(MODE_UNUSED_B, 32'hffff_ffff, sender_gap());
      // fill from both ends, extremes first
      for (int i = 0; i < dq_pkg::DEPTH; i++) begin
         case (i)
            0: v = 32'h7fff_ffff;
            1: v = 32'h8000_0000;
            2: v = 32'hffff_ffff;
            3: v = 32'h0000_0000;
            default: v = $urandom;
         endcase
         send_word(i[0] ? dq_pkg::MODE_PUSH_REAR : dq_pkg::MODE_PUSH_FRONT, v, sender_gap());
      end
      // pushes into a full queue, then peeks and pops at both ends
      send_word(dq_pkg::MODE_PUSH_FRONT, 32'h0000_0001, sender_gap());
      send_word(dq_pkg::MODE_PUSH_REAR, 32'h0000_0002, sender_gap());
      send_word(dq_pkg::MODE_PEEK_FRONT, 32'h0, sender_gap());
      send_word(dq_pkg::MODE_PEEK_REAR, 32'h0, sender_gap());
      send_word(dq_pkg::MODE_POP_FRONT, 32'h0, sender_gap());
      send_word(dq_pkg::MODE_POP_REAR, 32'h0, sender_gap());

      // segments with differing push bias so the queue swings between empty and full
      sent = 0;
      seg = 0;
      while (sent < RANDOM_WORDS) begin
         seg_len = $urandom_range(40, 150);
         case ($urandom_range(0, 4))
            0: push_pct = 5;
            1: push_pct = 25;
            2: push_pct = 50;
            3: push_pct = 75;
            default: push_pct = 95;
         endcase
         quiet = ($urandom_range(0, 4) == 0);
         if (seg == 4 || $urandom_range(0, 3) == 0)
            drain();
         if (seg == 2)
            long_hold_ask = 1'b1;
         for (int k = 0; k < seg_len; k++)
            send_word(random_mode(push_pct), random_value(), quiet ? 0 : sender_gap());
         sent += seg_len;
         seg++;
      end

      drain();
      repeat (10) @(posedge clock);
      if (board.errors == 0 && board.outstanding() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
